### rtl/hsj_pkg.sv
`default_nettype none

package hsj_pkg;

	// Tuple and key geometry
	localparam int NUM_COLS    = 4;
	localparam int VALUE_BITS  = 16;
	localparam int MAX_KEYS    = 4;
	localparam int KEY_BITS    = MAX_KEYS * VALUE_BITS;
	localparam int COUNT_BITS  = 24;
	localparam int EPOCH_BITS  = 8;
	localparam int IN_TDATA_W  = NUM_COLS * VALUE_BITS;
	localparam int OUT_TDATA_W = NUM_COLS * VALUE_BITS + COUNT_BITS;
	localparam int CMD_BITS    = 2;
	localparam int FLAG_BITS   = 2;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	// FNV-1a constants
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	// Command codes carried on the input tuser
	localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_PROBE  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_FINISH = 2'd2;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_KEY_COUNT     = 2'd0;
	localparam logic [1:0] REG_LEFT_COLUMNS  = 2'd1;
	localparam logic [1:0] REG_RIGHT_COLUMNS = 2'd2;

	typedef logic [NUM_COLS-1:0][VALUE_BITS-1:0] vals_t;
	typedef logic [MAX_KEYS-1:0][VALUE_BITS-1:0] key_t;

	typedef struct packed {
		logic [2:0] key_count;
		logic [7:0] left_columns;
		logic [7:0] right_columns;
	} cfg_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_ROUND,
		H_MOD,
		H_DONE
	} hash_state_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_EMIT
	} main_state_t;

	// Gather the key parts from the tuple; parts past the key count are zero.
	// Every 2-bit selector names an existing column.
	function automatic key_t build_key(vals_t vals, logic [7:0] sel, logic [2:0] kc);
		key_t key;
		logic [2:0] n;
		logic [1:0] col;
		n = (kc > 3'(MAX_KEYS)) ? 3'(MAX_KEYS) : kc;
		for (int i = 0; i < MAX_KEYS; i++) begin
			col = sel[2*i +: 2];
			key[i] = (3'(i) < n) ? vals[col] : '0;
		end
		return key;
	endfunction

endpackage

`default_nettype wire

### rtl/hsj_ram.sv
`default_nettype none

module hsj_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/hsj_hash.sv
`default_nettype none

module hsj_hash #(
	parameter int KEY_SLOTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  hsj_pkg::key_t                key,
	output logic                         done,
	output logic [$clog2(KEY_SLOTS)-1:0] slot
);

	import hsj_pkg::*;

	localparam int IDX_W = $clog2(KEY_SLOTS);
	localparam int RND_W = $clog2(MAX_KEYS);
	localparam bit POW2  = (KEY_SLOTS & (KEY_SLOTS - 1)) == 0;
	localparam logic [RND_W-1:0] LAST_RND = RND_W'(MAX_KEYS - 1);
	localparam logic [IDX_W:0]   MODULUS  = (IDX_W + 1)'(KEY_SLOTS);
	localparam logic [31:0]      SLOTS_W  = 32'(KEY_SLOTS);
	// floor(2^32 / KEY_SLOTS): the quotient estimate is low by at most one
	localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / KEY_SLOTS);

	hash_state_t      state_q, state_d;
	logic [RND_W-1:0] rnd_q;
	logic [31:0]      h_q;
	key_t             key_q;
	logic [1:0]       step_q;
	logic [31:0]      quo_q;
	logic [IDX_W:0]   r_q;
	logic [63:0]      prod;
	logic [31:0]      diff;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			H_IDLE:  if (start) state_d = H_ROUND;
			H_ROUND: if (rnd_q == LAST_RND) state_d = POW2 ? H_DONE : H_MOD;
			H_MOD:   if (step_q == 2'd2) state_d = H_DONE;
			H_DONE:  state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == H_DONE);
		slot = POW2 ? h_q[IDX_W-1:0] : r_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// remainder by reciprocal: quotient estimate, difference, one correction
	assign prod = 64'(h_q) * 64'(RECIP);
	assign diff = h_q - quo_q * SLOTS_W;

	// one FNV round per cycle, then three remainder steps when not a power of two
	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (start) begin
					key_q <= key;
					h_q   <= FNV_BASIS;
					rnd_q <= '0;
				end
			end
			H_ROUND: begin
				h_q    <= (h_q ^ 32'(key_q[rnd_q])) * FNV_PRIME;
				rnd_q  <= rnd_q + 1'b1;
				step_q <= '0;
			end
			H_MOD: begin
				case (step_q)
					2'd0:    quo_q <= prod[63:32];
					2'd1:    r_q   <= diff[IDX_W:0];
					default: r_q   <= (r_q >= MODULUS) ? r_q - MODULUS : r_q;
				endcase
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/hsj_cfg.sv
`default_nettype none

module hsj_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hsj_pkg::APB_AW-1:0]  paddr,
	input  logic [hsj_pkg::APB_DW-1:0]  pwdata,
	output logic [hsj_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output hsj_pkg::cfg_t               cfg
);

	import hsj_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_KEY_COUNT:     cfg_q.key_count     <= pwdata[2:0];
				REG_LEFT_COLUMNS:  cfg_q.left_columns  <= pwdata[7:0];
				REG_RIGHT_COLUMNS: cfg_q.right_columns <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_KEY_COUNT:     prdata = APB_DW'(cfg_q.key_count);
			REG_LEFT_COLUMNS:  prdata = APB_DW'(cfg_q.left_columns);
			REG_RIGHT_COLUMNS: prdata = APB_DW'(cfg_q.right_columns);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/hash_semi_join_filter_core.sv
`default_nettype none

// Hash semi-join filter. Load beats (tuser cmd 0) insert a key built from the
// right column selectors into an open-addressed set held in one synchronous
// RAM of KEY_SLOTS entries; probe beats (cmd 1) pass their
// tuple through only if the key built from the left selectors is present, or
// always when key_count is zero; a finish beat (cmd 2) returns a summary with
// the saturating kept count and the overflow flag, then empties the set.
// Timing: one item at a time. A load or probe with a non-empty key is
// accepted, hashed (4 FNV rounds and a hand-over, plus the remainder steps
// when KEY_SLOTS is not a power of two), then each slot examined (up to
// KEY_SLOTS slots) is read on the RAM read port and checked; a passing probe
// then loads the output register. The set is emptied by
// bumping an 8-bit epoch tag; after reset, and on every 255th finish when
// the tag wraps, a clearing pass over all KEY_SLOTS entries runs during which
// no beat is accepted (register writes still work). The output register lets
// the next beat be accepted while a result waits.
module hash_semi_join_filter_core #(
	parameter int KEY_SLOTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// value_a, value_b, value_c, value_d (16 bits each)
	input  logic [hsj_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic [hsj_pkg::CMD_BITS-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_a, out_b, out_c, out_d (16 bits each), kept_total (24 bits)
	output logic [hsj_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// is_summary, overflow
	output logic [hsj_pkg::FLAG_BITS-1:0]    m_axis_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hsj_pkg::APB_AW-1:0]       paddr,
	input  logic [hsj_pkg::APB_DW-1:0]       pwdata,
	output logic [hsj_pkg::APB_DW-1:0]       prdata,
	output logic                             pready
);

	import hsj_pkg::*;

	localparam int IDX_W = $clog2(KEY_SLOTS);
	localparam int MEM_W = EPOCH_BITS + KEY_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

	cfg_t                  cfg;
	main_state_t           state_q, state_d;

	logic                  accept;
	logic [CMD_BITS-1:0]   in_cmd;
	vals_t                 in_vals;
	key_t                  key_in;
	logic                  key_active;
	logic                  need_hash;

	logic                  hash_start;
	logic                  hash_done;
	logic [IDX_W-1:0]      hash_slot;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [MEM_W-1:0]      ram_wdata;
	logic [MEM_W-1:0]      ram_rdata;

	vals_t                 vals_q;
	key_t                  key_q;
	logic                  is_load_q;
	logic                  sum_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      clr_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [COUNT_BITS-1:0] kept_q;
	logic                  ovf_q;

	logic                  slot_live;
	logic                  hit;
	logic                  last_probe;
	logic                  resolved;
	logic                  out_free;
	logic                  out_load;

	logic                  m_valid_q;
	vals_t                 out_vals_q;
	logic [COUNT_BITS-1:0] out_total_q;
	logic                  out_sum_q;
	logic                  out_ovf_q;

	hsj_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input decode and key build
	assign in_cmd     = s_axis_tuser;
	assign in_vals    = s_axis_tdata;
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign key_active = (cfg.key_count != 3'd0);
	assign need_hash  = key_active && ((in_cmd == CMD_LOAD) || (in_cmd == CMD_PROBE));
	assign key_in     = build_key(in_vals,
		(in_cmd == CMD_LOAD) ? cfg.right_columns : cfg.left_columns, cfg.key_count);

	hsj_hash #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_in),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	// key store: {epoch tag, key}; an entry is live when its tag is the current epoch
	hsj_ram #(
		.WIDTH (MEM_W),
		.DEPTH (KEY_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// slot evaluation
	assign slot_live  = (ram_rdata[MEM_W-1 -: EPOCH_BITS] == epoch_q);
	assign hit        = slot_live && (ram_rdata[KEY_BITS-1:0] == key_q);
	assign last_probe = (cnt_q == LAST_IDX);
	assign resolved   = !slot_live || hit || last_probe;
	assign out_free   = !m_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == LAST_IDX) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_LOAD:   if (key_active) state_d = S_HASH;
						CMD_PROBE:  state_d = key_active ? S_HASH : S_EMIT;
						CMD_FINISH: state_d = S_EMIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_HASH:  if (hash_done) state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (resolved) begin
					state_d = (hit && !is_load_q) ? S_EMIT : S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = (sum_q && (epoch_q == '1)) ? S_CLEAR : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		hash_start    = (state_q == S_IDLE) && s_axis_tvalid && need_hash;
		out_load      = (state_q == S_EMIT) && out_free;
		ram_we        = (state_q == S_CLEAR) ||
			((state_q == S_CHECK) && is_load_q && !slot_live);
		ram_waddr     = (state_q == S_CLEAR) ? clr_q : pos_q;
		ram_wdata     = (state_q == S_CLEAR) ? '0 : {epoch_q, key_q};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			epoch_q   <= '0;
			kept_q    <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
			pos_q     <= '0;
			cnt_q     <= '0;
			is_load_q <= 1'b0;
			sum_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == S_CLEAR) begin
				if (clr_q == LAST_IDX) begin
					clr_q   <= '0;
					epoch_q <= EPOCH_BITS'(1);
				end else begin
					clr_q <= clr_q + 1'b1;
				end
			end

			if (accept) begin
				is_load_q <= (in_cmd == CMD_LOAD);
				sum_q     <= (in_cmd == CMD_FINISH);
			end

			if ((state_q == S_HASH) && hash_done) begin
				pos_q <= hash_slot;
				cnt_q <= '0;
			end

			// linear probing: step to the next slot, wrapping at the end
			if (state_q == S_CHECK) begin
				if (!resolved) begin
					pos_q <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end else if (is_load_q && slot_live && !hit) begin
					ovf_q <= 1'b1;
				end
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
				if (sum_q) begin
					kept_q  <= '0;
					ovf_q   <= 1'b0;
					epoch_q <= epoch_q + 1'b1;
				end else if (kept_q != '1) begin
					kept_q <= kept_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vals_q <= in_vals;
			key_q  <= key_in;
		end
		if (out_load) begin
			out_vals_q  <= sum_q ? '0 : vals_q;
			out_total_q <= sum_q ? kept_q : '0;
			out_sum_q   <= sum_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_total_q, out_vals_q};
	assign m_axis_tuser  = {out_ovf_q, out_sum_q};

`ifndef NO_ASSERTIONS
	// the store is only written by the clearing pass or by an insert
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_CLEAR) || (state_q == S_CHECK)))
		else $error("key store written outside clear or insert");

	// epoch zero marks cleared entries and must never be current in service
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (epoch_q != '0))
		else $error("epoch zero in use outside the clearing pass");

	// a summary leaves count and overflow cleared
	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && sum_q) |=> ((kept_q == '0) && !ovf_q))
		else $error("summary did not clear count and overflow");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import hsj_pkg::*;

	localparam int SLOTS     = 1024;
	localparam int GAP_MAX   = 14;
	localparam int SETTLE    = 2 * SLOTS + 64;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
	localparam logic [CMD_BITS-1:0]   CMD_NONE  = 2'd3;

	// One output beat: kept tuple or finish summary
	typedef struct {
		vals_t                 tuple;
		logic [COUNT_BITS-1:0] total;
		logic                  summary;
		logic                  ovf;
	} join_beat_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// value_a, value_b, value_c, value_d (16 bits each)
	logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
	// cmd
	logic [CMD_BITS-1:0]     s_axis_tuser  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// out_a, out_b, out_c, out_d (16 bits each), kept_total (24 bits)
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	// is_summary, overflow
	logic [FLAG_BITS-1:0]    m_axis_tuser;
	logic                    psel          = 1'b0;
	logic                    penable       = 1'b0;
	logic                    pwrite        = 1'b0;
	logic [APB_AW-1:0]       paddr         = '0;
	logic [APB_DW-1:0]       pwdata        = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;

	hash_semi_join_filter_core #(
		.KEY_SLOTS(SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// Shadow of the block: registers, key set, kept count, overflow flag
	logic [2:0]            cfg_kc    = '0;
	logic [7:0]            cfg_left  = '0;
	logic [7:0]            cfg_right = '0;
	key_t                  slot_key [SLOTS];
	bit                    slot_used [SLOTS];
	logic [COUNT_BITS-1:0] kept_count = '0;
	bit                    ovf_seen   = 1'b0;

	join_beat_t join_outputs [$];
	int         mismatches      = 0;
	bit         quiet           = 1'b0;
	int         hold_off_cycles = 0;
	logic [VALUE_BITS-1:0] pool [4];

	function automatic int key_parts();
		return (cfg_kc > 3'(MAX_KEYS)) ? MAX_KEYS : int'(cfg_kc);
	endfunction

	function automatic key_t gather_key(input vals_t v, input logic [7:0] sel);
		key_t k;
		for (int i = 0; i < MAX_KEYS; i++)
			k[i] = (i < key_parts()) ? v[sel[2*i +: 2]] : '0;
		return k;
	endfunction

	// FNV-1a over the four key parts, reduced to a slot index
	function automatic int slot_of(input key_t k);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < MAX_KEYS; i++)
			h = (h ^ 32'(k[i])) * FNV_PRIME;
		return int'(h % SLOTS);
	endfunction

	// Linear probe; slot gets the hit or first free slot, -1 when full
	function automatic bit locate_key(input key_t k, output int slot);
		int pos;
		pos  = slot_of(k);
		slot = -1;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_used[pos]) begin
				slot = pos;
				return 1'b0;
			end
			if (slot_key[pos] == k) begin
				slot = pos;
				return 1'b1;
			end
			pos = (pos + 1) % SLOTS;
		end
		return 1'b0;
	endfunction

	function automatic void semi_join_step(input logic [CMD_BITS-1:0] cmd, input vals_t v);
		key_t       k;
		int         slot;
		bit         pass;
		join_beat_t r;
		case (cmd)
			CMD_LOAD: begin
				if (key_parts() != 0) begin
					k = gather_key(v, cfg_right);
					if (!locate_key(k, slot)) begin
						if (slot >= 0) begin
							slot_key[slot]  = k;
							slot_used[slot] = 1'b1;
						end else begin
							ovf_seen = 1'b1;
						end
					end
				end
			end
			CMD_PROBE: begin
				pass = 1'b1;
				if (key_parts() != 0)
					pass = locate_key(gather_key(v, cfg_left), slot);
				if (pass) begin
					if (kept_count != COUNT_TOP)
						kept_count++;
					r.tuple   = v;
					r.total   = '0;
					r.summary = 1'b0;
					r.ovf     = ovf_seen;
					join_outputs = {join_outputs, r};
				end
			end
			CMD_FINISH: begin
				r.tuple   = '0;
				r.total   = kept_count;
				r.summary = 1'b1;
				r.ovf     = ovf_seen;
				join_outputs = {join_outputs, r};
				foreach (slot_used[i])
					slot_used[i] = 1'b0;
				kept_count = '0;
				ovf_seen   = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic vals_t tup(input logic [15:0] a, b, c, d);
		return {d, c, b, a};
	endfunction

	function automatic vals_t rand_tuple();
		vals_t v;
		for (int i = 0; i < NUM_COLS; i++)
			v[i] = VALUE_BITS'($urandom);
		return v;
	endfunction

	// Columns mostly from a small shared pool so that keys meet
	function automatic vals_t pool_tuple();
		vals_t v;
		for (int i = 0; i < NUM_COLS; i++)
			v[i] = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 3)]
				: VALUE_BITS'($urandom);
		return v;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	// Result checker
	always @(posedge clk) begin : check_beats
		join_beat_t want;
		vals_t      got_tuple;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_tuple = m_axis_tdata[IN_TDATA_W-1:0];
			if (join_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none got %h / %h",
					$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = join_outputs.pop_front();
				for (int i = 0; i < NUM_COLS; i++)
					check_field($sformatf("out column %0d", i), 32'(want.tuple[i]),
						32'(got_tuple[i]));
				check_field("kept_total", 32'(want.total),
					32'(m_axis_tdata[IN_TDATA_W +: COUNT_BITS]));
				check_field("is_summary", 32'(want.summary), 32'(m_axis_tuser[0]));
				check_field("overflow", 32'(want.ovf), 32'(m_axis_tuser[1]));
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin : result_side
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(input logic [CMD_BITS-1:0] cmd, input vals_t v);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		semi_join_step(cmd, v);
	endtask

	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		while (join_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_KEY_COUNT:     cfg_kc    = val[2:0];
			REG_LEFT_COLUMNS:  cfg_left  = val[7:0];
			REG_RIGHT_COLUMNS: cfg_right = val[7:0];
			default: ;
		endcase
	endtask

	// Registers change only once the block has gone quiet
	task automatic set_config(input logic [2:0] kc, input logic [7:0] left,
			input logic [7:0] right);
		wait_results();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_KEY_COUNT, APB_DW'(kc));
		write_reg(REG_LEFT_COLUMNS, APB_DW'(left));
		write_reg(REG_RIGHT_COLUMNS, APB_DW'(right));
	endtask

	// Field extremes, zero and oversized key counts, duplicates, unknown command
	task automatic test_directed();
		set_config(3'd0, 8'hE4, 8'h1B);
		send_item(CMD_LOAD, tup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(CMD_PROBE, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_item(CMD_PROBE, tup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(CMD_PROBE, tup(16'h0001, 16'h0002, 16'h0004, 16'h0008));
		send_item(CMD_NONE, tup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(CMD_FINISH, tup(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));

		// left key (c, a), right key (b, d)
		set_config(3'd2, 8'hA2, 8'h5D);
		send_item(CMD_LOAD, tup(16'h1111, 16'hABCD, 16'h2222, 16'h5555));
		send_item(CMD_LOAD, tup(16'h9999, 16'hABCD, 16'h0000, 16'h5555));
		send_item(CMD_LOAD, tup(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_item(CMD_PROBE, tup(16'h5555, 16'h0000, 16'hABCD, 16'h0000));
		send_item(CMD_PROBE, tup(16'hABCD, 16'h0000, 16'h5555, 16'h0000));
		send_item(CMD_PROBE, tup(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(CMD_PROBE, tup(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
		send_item(CMD_NONE, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_item(CMD_FINISH, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));

		// key count past the limit: left key d x4, right key a x4
		set_config(3'd7, 8'hFF, 8'h00);
		send_item(CMD_LOAD, tup(16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC));
		send_item(CMD_LOAD, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_item(CMD_PROBE, tup(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
		send_item(CMD_PROBE, tup(16'h0000, 16'h0000, 16'h0000, 16'h0001));
		send_item(CMD_PROBE, tup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_item(CMD_FINISH, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));

		set_config(3'd4, 8'hE4, 8'hE4);
		send_item(CMD_LOAD, tup(16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3));
		send_item(CMD_PROBE, tup(16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3));
		send_item(CMD_PROBE, tup(16'h0F0F, 16'hF0F0, 16'h3C3D, 16'hC3C3));
		send_item(CMD_FINISH, tup(16'h0000, 16'h0000, 16'h0000, 16'h0000));
	endtask

	// Fill every slot, then push past it so the overflow flag shows
	task automatic test_fill_overflow();
		logic [15:0] base;
		vals_t       v;
		set_config(3'd1, 8'hFC, 8'h00);
		base = VALUE_BITS'($urandom);
		for (int i = 0; i < SLOTS; i++) begin
			quiet = (i < SLOTS / 2);
			v = rand_tuple();
			v[0] = base + 16'(i);
			send_item(CMD_LOAD, v);
		end
		quiet = 1'b0;
		for (int j = 0; j < 4; j++) begin
			v = rand_tuple();
			v[0] = base + 16'(SLOTS + j);
			send_item(CMD_LOAD, v);
		end
		v = rand_tuple();
		v[0] = base;
		send_item(CMD_LOAD, v);
		for (int j = 0; j < 20; j++) begin
			v = rand_tuple();
			v[0] = base + 16'($urandom_range(0, SLOTS - 1));
			send_item(CMD_PROBE, v);
		end
		for (int j = 0; j < 2; j++) begin
			v = rand_tuple();
			v[0] = base + 16'(2 * SLOTS + j);
			send_item(CMD_PROBE, v);
		end
		send_item(CMD_FINISH, rand_tuple());
		// set is empty again, flag cleared
		v = rand_tuple();
		v[0] = base;
		send_item(CMD_PROBE, v);
		send_item(CMD_LOAD, v);
		send_item(CMD_PROBE, v);
		send_item(CMD_FINISH, rand_tuple());
	endtask

	// Long result stall while probes keep coming, then a full drain
	task automatic test_backpressure();
		vals_t       stored [8];
		logic [7:0]  sel;
		sel = 8'($urandom);
		set_config(3'd3, sel, sel);
		foreach (stored[i]) begin
			stored[i] = rand_tuple();
			send_item(CMD_LOAD, stored[i]);
		end
		hold_off_cycles = 400;
		quiet = 1'b1;
		for (int j = 0; j < 30; j++)
			send_item(CMD_PROBE, stored[$urandom_range(0, 7)]);
		wait_results();
		quiet = 1'b0;
		for (int j = 0; j < 10; j++)
			send_item(CMD_PROBE, ($urandom_range(0, 1) != 0) ? stored[$urandom_range(0, 7)]
				: rand_tuple());
		send_item(CMD_FINISH, rand_tuple());
	endtask

	// Enough finishes to wrap the clear tag; stale keys must not come back
	task automatic test_epoch_wrap();
		logic [15:0] prev_key;
		vals_t       v;
		set_config(3'd1, 8'h03, 8'h00);
		prev_key = VALUE_BITS'($urandom);
		for (int i = 0; i < 258; i++) begin
			if (i % 8 == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
				v = rand_tuple();
				v[3] = prev_key;
				send_item(CMD_PROBE, v);
				v = rand_tuple();
				prev_key = v[0];
				send_item(CMD_LOAD, v);
				v = rand_tuple();
				v[3] = prev_key;
				send_item(CMD_PROBE, v);
			end
			send_item(CMD_FINISH, rand_tuple());
		end
		quiet = 1'b0;
	endtask

	// Phases of random configuration with mostly well-formed load/probe runs
	task automatic test_random_mix();
		int pick;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       set_config(3'd4, 8'hFF, 8'hFF);
				1:       set_config(3'd0, 8'($urandom), 8'($urandom));
				2:       set_config(3'd7, 8'h00, 8'h00);
				default: set_config(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
			endcase
			foreach (pool[i])
				pool[i] = VALUE_BITS'($urandom);
			quiet = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < 30; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					send_item(CMD_LOAD, pool_tuple());
				else if (pick < 85)
					send_item(CMD_PROBE, pool_tuple());
				else if (pick < 93)
					send_item(CMD_FINISH, rand_tuple());
				else
					send_item(CMD_NONE, rand_tuple());
			end
			send_item(CMD_FINISH, rand_tuple());
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_overflow();
		test_backpressure();
		test_epoch_wrap();
		test_random_mix();
		wait_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Run limit
	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
